FILE: design/cdfc_pkg.sv
package cdfc_pkg;

  localparam int unsigned LSectBytes   = 2048;
  localparam int unsigned LSectW       = 11;
  localparam int unsigned MaxReadBytes = 129024;
  localparam int unsigned CountW       = 17;
  localparam int unsigned ChunkW       = 12;
  localparam int unsigned RssW         = 12;
  localparam int unsigned HoffW        = 9;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 32;

  localparam logic [CfgIdxW-1:0] CfgFileStartSector = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFileLength      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRawSectorSize   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgHeaderOffset    = 2'd3;

  localparam logic       ReqRead      = 1'b0;
  localparam logic       ReqSeek      = 1'b1;
  localparam logic [1:0] WhenceStart  = 2'd0;
  localparam logic [1:0] WhenceCur    = 2'd1;
  localparam logic [1:0] WhenceEnd    = 2'd2;
  localparam logic [1:0] WhenceBad    = 2'd3;

  localparam logic StatusOk        = 1'b0;
  localparam logic StatusBadWhence = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [1:0]         seek_whence;
    logic signed [63:0] seek_offset;
    logic [CountW-1:0]  read_count;
  } cdfc_req_t;

  typedef struct packed {
    logic [31:0]       raw_addr;
    logic [ChunkW-1:0] chunk_length;
    logic              last;
    logic              status;
    logic [31:0]       position;
    logic [CountW-1:0] bytes_granted;
  } cdfc_res_t;

  typedef struct packed {
    logic load;
    logic emit_nil;
    logic nil_bad;
    logic seek_sum;
    logic seek_fin;
    logic rd_prep;
    logic rd_mul;
    logic rd_chunk;
  } cdfc_cmd_t;

  typedef struct packed {
    logic is_seek;
    logic bad_whence;
    logic rd_empty;
    logic chunk_last;
  } cdfc_sts_t;

endpackage

FILE: design/cd_image_file_cursor_top.sv
// Steps after accept: invalid-origin seek or empty read: decode; seek: decode, seek;
// read: decode, multiply, then one chunk per cycle (up to 64 chunks).
// Throughput: one request at a time; busy drops once the final word is registered,
// so a read holds it until the one-chunk-per-cycle sequencer emits its last chunk.
// Results are one-cycle strobes; the receiver cannot stall.
// Reset (rst_ni low, async) clears cursor and state and loads the register defaults.
module cd_image_file_cursor_top import cdfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  cdfc_req_t           req_i,
  output cdfc_res_t           res_o,
  output logic                res_valid_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cdfc_cmd_t cmd;
  cdfc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  cdfc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  cdfc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

FILE: design/cdfc_ctrl.sv
module cdfc_ctrl import cdfc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  cdfc_sts_t sts_i,
  output cdfc_cmd_t cmd_o
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SDecode = 3'd1;
  localparam logic [2:0] SSeek   = 3'd2;
  localparam logic [2:0] SRdMul  = 3'd3;
  localparam logic [2:0] SRdEmit = 3'd4;

  logic [2:0] state_q, state_d;

  assign busy = (state_q != SIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = SDecode;
        end
      end
      SDecode: begin
        if (sts_i.is_seek) begin
          if (sts_i.bad_whence) begin
            cmd_o.emit_nil = 1'b1;
            cmd_o.nil_bad  = 1'b1;
            state_d        = SIdle;
          end else begin
            cmd_o.seek_sum = 1'b1;
            state_d        = SSeek;
          end
        end else if (sts_i.rd_empty) begin
          cmd_o.emit_nil = 1'b1;
          state_d        = SIdle;
        end else begin
          cmd_o.rd_prep = 1'b1;
          state_d       = SRdMul;
        end
      end
      SSeek: begin
        cmd_o.seek_fin = 1'b1;
        state_d        = SIdle;
      end
      SRdMul: begin
        cmd_o.rd_mul = 1'b1;
        state_d      = SRdEmit;
      end
      SRdEmit: begin
        cmd_o.rd_chunk = 1'b1;
        if (sts_i.chunk_last) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/cdfc_dp.sv
module cdfc_dp import cdfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cdfc_req_t           req_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  cdfc_cmd_t           cmd_i,
  output cdfc_sts_t           sts_o,
  output cdfc_res_t           res_o,
  output logic                res_valid_o
);

  logic [31:0]       fss_q, flen_q;
  logic [RssW-1:0]   rss_q;
  logic [HoffW-1:0]  hoff_q;
  logic [31:0]       cursor_q, cursor_d;

  cdfc_req_t         req_q;
  logic [65:0]       sum_q;
  logic [CountW-1:0] count_q, left_q;
  logic [31:0]       logical_q;
  logic [31:0]       rbase_q;
  logic [LSectW-1:0] within_q;
  cdfc_res_t         res_q, res_d;
  logic              res_valid_q;

  logic [31:0]       seek_base;
  logic [65:0]       sum_d;
  logic [31:0]       new_pos;
  logic [CountW-1:0] cnt_cap, count_d;
  logic [32:0]       prod;
  logic [ChunkW-1:0] room, chunk;
  logic [CountW-1:0] left_n;
  logic              chunk_last;
  logic [31:0]       raw_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fss_q  <= '0;
      flen_q <= '0;
      rss_q  <= RssW'(LSectBytes);
      hoff_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFileStartSector: fss_q  <= cfg_data_i;
        CfgFileLength:      flen_q <= cfg_data_i;
        CfgRawSectorSize:   rss_q  <= cfg_data_i[RssW-1:0];
        CfgHeaderOffset:    hoff_q <= cfg_data_i[HoffW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (req_q.seek_whence)
      WhenceStart: seek_base = '0;
      WhenceCur:   seek_base = cursor_q;
      default:     seek_base = flen_q;
    endcase
    sum_d = {34'b0, seek_base} + {{2{req_q.seek_offset[63]}}, req_q.seek_offset};

    if (sum_q[65]) begin
      new_pos = '0;
    end else if (sum_q > {34'b0, flen_q}) begin
      new_pos = flen_q;
    end else begin
      new_pos = sum_q[31:0];
    end

    cnt_cap = (req_q.read_count > CountW'(MaxReadBytes)) ? CountW'(MaxReadBytes)
                                                          : req_q.read_count;
    count_d = ({15'b0, cnt_cap} > (flen_q - cursor_q)) ? (flen_q[CountW-1:0] -
              cursor_q[CountW-1:0]) : cnt_cap;

    prod = {12'b0, logical_q[31:LSectW]} * {21'b0, rss_q};

    room       = ChunkW'(LSectBytes) - {1'b0, within_q};
    chunk_last = (left_q <= {5'b0, room});
    chunk      = chunk_last ? left_q[ChunkW-1:0] : room;
    left_n     = left_q - {5'b0, chunk};
    raw_now    = rbase_q + {23'b0, hoff_q} + {21'b0, within_q};
  end

  assign sts_o.is_seek    = (req_q.req_type == ReqSeek);
  assign sts_o.bad_whence = (req_q.seek_whence == WhenceBad);
  assign sts_o.rd_empty   = (cursor_q >= flen_q) || (req_q.read_count == '0);
  assign sts_o.chunk_last = chunk_last;

  always_comb begin
    cursor_d = cursor_q;
    res_d    = res_q;
    if (cmd_i.emit_nil) begin
      res_d.raw_addr      = '0;
      res_d.chunk_length  = '0;
      res_d.last          = 1'b1;
      res_d.status        = cmd_i.nil_bad ? StatusBadWhence : StatusOk;
      res_d.position      = cursor_q;
      res_d.bytes_granted = '0;
    end
    if (cmd_i.seek_fin) begin
      cursor_d            = new_pos;
      res_d.raw_addr      = '0;
      res_d.chunk_length  = '0;
      res_d.last          = 1'b1;
      res_d.status        = StatusOk;
      res_d.position      = new_pos;
      res_d.bytes_granted = '0;
    end
    if (cmd_i.rd_mul) begin
      cursor_d = cursor_q + {15'b0, count_q};
    end
    if (cmd_i.rd_chunk) begin
      res_d.raw_addr      = raw_now;
      res_d.chunk_length  = chunk;
      res_d.last          = chunk_last;
      res_d.status        = StatusOk;
      res_d.position      = cursor_q;
      res_d.bytes_granted = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      cursor_q    <= cursor_d;
      res_valid_q <= cmd_i.emit_nil | cmd_i.seek_fin | cmd_i.rd_chunk;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.seek_sum) begin
      sum_q <= sum_d;
    end
    if (cmd_i.rd_prep) begin
      count_q   <= count_d;
      logical_q <= {fss_q[31-LSectW:0], {LSectW{1'b0}}} + cursor_q;
    end
    if (cmd_i.rd_mul) begin
      rbase_q  <= prod[31:0];
      left_q   <= count_q;
      within_q <= logical_q[LSectW-1:0];
    end
    if (cmd_i.rd_chunk) begin
      rbase_q   <= (&logical_q[31:LSectW]) ? '0 : rbase_q + {20'b0, rss_q};
      logical_q <= {logical_q[31:LSectW] + (32-LSectW)'(1), logical_q[LSectW-1:0]};
      left_q    <= left_n;
      within_q  <= '0;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule
